/* hw/rtl/dsi_pkg.sv */
// Types, constants and the microcode store shared by the damped spring integrator.
`default_nettype none
package dsi_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned COEF_W    = 20;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned MUL_A_W   = 44;
  localparam int unsigned ACC_W     = 44;
  localparam int unsigned PROD_W    = 53;
  localparam int unsigned SUM_W     = 38;
  localparam int unsigned REM_W     = 16;
  localparam int unsigned DT_W      = 9;
  localparam int unsigned FRAC_K    = 10;
  localparam int unsigned FRAC_T    = 16;

  localparam logic [REM_W-1:0]  MAX_DELTA    = 16'd65535;
  localparam logic [DT_W-1:0]   SUBSTEP      = 9'd273;
  localparam logic [COEF_W-1:0] STIFF_RESET  = 20'd122880;
  localparam logic [COEF_W-1:0] DAMP_RESET   = 20'd6144;
  localparam logic signed [DATA_W-1:0] REST_LIMIT = 32'sd7;

  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 8'd1;

  typedef enum logic [1:0] {
    REQ_UPDATE = 2'd0,
    REQ_KICK   = 2'd1,
    REQ_SET    = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_MUL_KX  = 3'd0,
    ST_MUL_CV  = 3'd1,
    ST_ACC_SUB = 3'd2,
    ST_MUL_AD  = 3'd3,
    ST_UPD_V   = 3'd4,
    ST_MUL_VD  = 3'd5,
    ST_UPD_X   = 3'd6,
    ST_FINISH  = 3'd7
  } step_t;

  typedef enum logic [1:0] {
    A_X   = 2'd0,
    A_V   = 2'd1,
    A_ACC = 2'd2
  } a_sel_t;

  typedef enum logic [1:0] {
    B_K  = 2'd0,
    B_C  = 2'd1,
    B_DT = 2'd2
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD     = 2'd0,
    ACC_LOAD_NEG = 2'd1,
    ACC_SUB      = 2'd2
  } acc_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT = 2'd0,
    JMP_LOOP = 2'd1,
    JMP_END  = 2'd2
  } jmp_t;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    logic    mul_en;
    acc_op_t acc_op;
    logic    v_upd;
    logic    x_upd;
    jmp_t    jmp;
    step_t   target;
  } uword_t;

  typedef struct packed {
    logic   busy;
    uword_t uw;
  } ctrl_t;

  typedef struct packed {
    logic more;
    logic out_free;
  } cond_t;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{a_sel: A_X, b_sel: B_K, mul_en: 1'b0, acc_op: ACC_HOLD, v_upd: 1'b0,
          x_upd: 1'b0, jmp: JMP_NEXT, target: ST_MUL_KX};
    case (s)
      ST_MUL_KX: begin
        w.a_sel = A_X; w.b_sel = B_K; w.mul_en = 1'b1;
      end
      ST_MUL_CV: begin
        w.a_sel = A_V; w.b_sel = B_C; w.mul_en = 1'b1; w.acc_op = ACC_LOAD_NEG;
      end
      ST_ACC_SUB: begin
        w.acc_op = ACC_SUB;
      end
      ST_MUL_AD: begin
        w.a_sel = A_ACC; w.b_sel = B_DT; w.mul_en = 1'b1;
      end
      ST_UPD_V: begin
        w.v_upd = 1'b1;
      end
      ST_MUL_VD: begin
        w.a_sel = A_V; w.b_sel = B_DT; w.mul_en = 1'b1;
      end
      ST_UPD_X: begin
        w.x_upd = 1'b1; w.jmp = JMP_LOOP; w.target = ST_MUL_KX;
      end
      ST_FINISH: begin
        w.jmp = JMP_END;
      end
      default: begin
        w.jmp = JMP_END;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(32'sh7FFF_FFFF);
    lo = -(SUM_W'(32'sh7FFF_FFFF)) - SUM_W'(1);
    if (s > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (s < lo) begin
      return 32'sh8000_0000;
    end
    return s[DATA_W-1:0];
  endfunction

  function automatic logic is_small(input logic signed [DATA_W-1:0] v);
    return (v <= REST_LIMIT) && (v >= -REST_LIMIT);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/dsi_if.sv */
// Request, result and register write channels of the damped spring integrator.
`default_nettype none
interface dsi_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           req_type;
  logic signed [dsi_pkg::DATA_W-1:0]    operand;
  modport source (output valid, req_type, operand, input ready);
  modport sink   (input valid, req_type, operand, output ready);
endinterface

interface dsi_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dsi_pkg::DATA_W-1:0]    position;
  logic signed [dsi_pkg::DATA_W-1:0]    velocity_out;
  logic                                 at_rest;
  modport source (output valid, position, velocity_out, at_rest, input ready);
  modport sink   (input valid, position, velocity_out, at_rest, output ready);
endinterface

interface dsi_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [dsi_pkg::CFG_IDX_W-1:0]        index;
  logic [dsi_pkg::DATA_W-1:0]           data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/dsi_mul.sv */
// Shared signed-by-unsigned multiplier with registered product.
`default_nettype none
module dsi_mul (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [dsi_pkg::MUL_A_W-1:0]   a,
  input  wire logic [dsi_pkg::COEF_W-1:0]           b,
  output logic signed [dsi_pkg::PROD_W-1:0]         prod_r
);

  logic signed [dsi_pkg::MUL_A_W+dsi_pkg::COEF_W:0] full;

  assign full = a * $signed({1'b0, b});

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= full[dsi_pkg::PROD_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/dsi_useq.sv */
// Microcode sequencer: step counter, control store and loop jump.
`default_nettype none
module dsi_useq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire dsi_pkg::cond_t cond,
  output dsi_pkg::ctrl_t      ctrl
);

  logic           busy_r;
  dsi_pkg::step_t step_r;
  dsi_pkg::uword_t uw;

  assign uw        = dsi_pkg::ucode(step_r);
  assign ctrl.busy = busy_r;
  assign ctrl.uw   = uw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= dsi_pkg::ST_MUL_KX;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= dsi_pkg::ST_MUL_KX;
    end else if (busy_r) begin
      case (uw.jmp)
        dsi_pkg::JMP_NEXT: begin
          step_r <= dsi_pkg::step_t'(step_r + 3'd1);
        end
        dsi_pkg::JMP_LOOP: begin
          step_r <= cond.more ? uw.target : dsi_pkg::step_t'(step_r + 3'd1);
        end
        dsi_pkg::JMP_END: begin
          if (cond.out_free) begin
            busy_r <= 1'b0;
          end
        end
        default: begin
          busy_r <= 1'b0;
        end
      endcase
    end
  end

  a_start_enters: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && step_r == dsi_pkg::ST_MUL_KX)
    else $error("sequencer did not enter program on start");

  a_end_only: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(uw.jmp == dsi_pkg::JMP_END && cond.out_free))
    else $error("sequencer left program outside its end step");

  a_loop_needs_more: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start && uw.jmp == dsi_pkg::JMP_LOOP && cond.more |=> step_r == uw.target)
    else $error("sequencer missed loop jump");

endmodule
`default_nettype wire

/* hw/rtl/damped_spring_integrator_top.sv */
// Top level of the damped spring integrator: handshakes, registers, state datapath.
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    req_type[1:0], operand[31:0] signed
//  out_ch    out  valid/ready    position[31:0], velocity_out[31:0], at_rest
//  cfg_ch    in   valid/ready    index[7:0], data[31:0] (low 20 bits kept)
//
//  Kick, set, clear and a non-positive delta: the result is registered directly on accept.
//  Update: each sub-step of at most 273 runs MUL_KX, MUL_CV, ACC_SUB, MUL_AD, UPD_V,
//  MUL_VD and UPD_X through the one shared multiplier; a finish step follows the last.
//  Reset returns stiffness 120.0, damping 6.0, zero state; no clearing pass.
//  A new item is taken when no update runs and the result register is free or drains.
//  The finish step holds while an earlier result is still waiting.
`default_nettype none
module damped_spring_integrator_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dsi_req_if.sink    in_ch,
  dsi_rsp_if.source  out_ch,
  dsi_cfg_if.sink    cfg_ch
);

  logic [dsi_pkg::COEF_W-1:0]          stiff_r, damp_r;
  logic signed [dsi_pkg::DATA_W-1:0]   x_r, x_nxt, v_r, v_nxt;
  logic signed [dsi_pkg::ACC_W-1:0]    acc_r, acc_nxt;
  logic [dsi_pkg::REM_W-1:0]           rem_r, rem_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic signed [dsi_pkg::DATA_W-1:0]   pos_r, pos_nxt, vel_r, vel_nxt;
  logic                                rest_r, rest_nxt;

  logic                                in_ready, accept, start, out_free;
  logic [dsi_pkg::DT_W-1:0]            dt;
  logic signed [dsi_pkg::MUL_A_W-1:0]  mul_a;
  logic [dsi_pkg::COEF_W-1:0]          mul_b;
  logic signed [dsi_pkg::PROD_W-1:0]   prod_r;
  logic signed [dsi_pkg::PROD_W-dsi_pkg::FRAC_K-1:0] prod_k;
  logic signed [dsi_pkg::PROD_W-dsi_pkg::FRAC_T-1:0] prod_t;
  logic signed [dsi_pkg::SUM_W-1:0]    v_sum, x_sum, kick_sum;
  dsi_pkg::ctrl_t                      ctrl;
  dsi_pkg::cond_t                      cond;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ready  = !ctrl.busy && out_free;
  assign accept    = in_ch.valid && in_ready;
  assign start     = accept && in_ch.req_type == dsi_pkg::REQ_UPDATE && in_ch.operand > 0;

  assign in_ch.ready         = in_ready;
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.position     = pos_r;
  assign out_ch.velocity_out = vel_r;
  assign out_ch.at_rest      = rest_r;

  assign dt = (rem_r < dsi_pkg::REM_W'(dsi_pkg::SUBSTEP)) ? rem_r[dsi_pkg::DT_W-1:0]
                                                          : dsi_pkg::SUBSTEP;
  assign cond.more     = rem_r > dsi_pkg::REM_W'(dsi_pkg::SUBSTEP);
  assign cond.out_free = out_free;

  dsi_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cond  (cond),
    .ctrl  (ctrl)
  );

  always_comb begin
    mul_a = dsi_pkg::MUL_A_W'(x_r);
    mul_b = stiff_r;
    case (ctrl.uw.a_sel)
      dsi_pkg::A_X:   mul_a = dsi_pkg::MUL_A_W'(x_r);
      dsi_pkg::A_V:   mul_a = dsi_pkg::MUL_A_W'(v_r);
      dsi_pkg::A_ACC: mul_a = acc_r;
      default:        mul_a = dsi_pkg::MUL_A_W'(x_r);
    endcase
    case (ctrl.uw.b_sel)
      dsi_pkg::B_K:  mul_b = stiff_r;
      dsi_pkg::B_C:  mul_b = damp_r;
      dsi_pkg::B_DT: mul_b = dsi_pkg::COEF_W'(dt);
      default:       mul_b = stiff_r;
    endcase
  end

  dsi_mul u_mul (
    .clk    (clk),
    .en     (ctrl.busy && ctrl.uw.mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign prod_k   = prod_r[dsi_pkg::PROD_W-1:dsi_pkg::FRAC_K];
  assign prod_t   = prod_r[dsi_pkg::PROD_W-1:dsi_pkg::FRAC_T];
  assign v_sum    = dsi_pkg::SUM_W'(v_r) + dsi_pkg::SUM_W'(prod_t);
  assign x_sum    = dsi_pkg::SUM_W'(x_r) + dsi_pkg::SUM_W'(prod_t);
  assign kick_sum = dsi_pkg::SUM_W'(v_r) + dsi_pkg::SUM_W'(in_ch.operand);

  always_comb begin
    x_nxt         = x_r;
    v_nxt         = v_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    pos_nxt       = pos_r;
    vel_nxt       = vel_r;
    rest_nxt      = rest_r;
    if (accept) begin
      case (in_ch.req_type)
        dsi_pkg::REQ_UPDATE: begin
          if (in_ch.operand > 32'sd65535) begin
            rem_nxt = dsi_pkg::MAX_DELTA;
          end else begin
            rem_nxt = in_ch.operand[dsi_pkg::REM_W-1:0];
          end
        end
        dsi_pkg::REQ_KICK:  v_nxt = dsi_pkg::sat32(kick_sum);
        dsi_pkg::REQ_SET:   x_nxt = in_ch.operand;
        dsi_pkg::REQ_CLEAR: begin
          x_nxt = '0;
          v_nxt = '0;
        end
        default: begin
          x_nxt = x_r;
        end
      endcase
      if (!start) begin
        out_valid_nxt = 1'b1;
        pos_nxt       = x_nxt;
        vel_nxt       = v_nxt;
        rest_nxt      = dsi_pkg::is_small(x_nxt) && dsi_pkg::is_small(v_nxt);
      end
    end else if (ctrl.busy) begin
      case (ctrl.uw.acc_op)
        dsi_pkg::ACC_LOAD_NEG: acc_nxt = -dsi_pkg::ACC_W'(prod_k);
        dsi_pkg::ACC_SUB:      acc_nxt = acc_r - dsi_pkg::ACC_W'(prod_k);
        default:               acc_nxt = acc_r;
      endcase
      if (ctrl.uw.v_upd) begin
        v_nxt = dsi_pkg::sat32(v_sum);
      end
      if (ctrl.uw.x_upd) begin
        x_nxt   = dsi_pkg::sat32(x_sum);
        rem_nxt = rem_r - dsi_pkg::REM_W'(dt);
      end
      if (ctrl.uw.jmp == dsi_pkg::JMP_END && out_free) begin
        rest_nxt      = dsi_pkg::is_small(x_r) && dsi_pkg::is_small(v_r);
        if (rest_nxt) begin
          x_nxt = '0;
          v_nxt = '0;
        end
        out_valid_nxt = 1'b1;
        pos_nxt       = x_nxt;
        vel_nxt       = v_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r     <= dsi_pkg::STIFF_RESET;
      damp_r      <= dsi_pkg::DAMP_RESET;
      x_r         <= '0;
      v_r         <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.index == dsi_pkg::REG_STIFFNESS) begin
        stiff_r <= cfg_ch.data[dsi_pkg::COEF_W-1:0];
      end
      if (cfg_ch.valid && cfg_ch.index == dsi_pkg::REG_DAMPING) begin
        damp_r <= cfg_ch.data[dsi_pkg::COEF_W-1:0];
      end
      x_r         <= x_nxt;
      v_r         <= v_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
    acc_r  <= acc_nxt;
    pos_r  <= pos_nxt;
    vel_r  <= vel_nxt;
    rest_r <= rest_nxt;
  end

  a_update_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ctrl.busy && !out_valid_r)
    else $error("update item did not start the program");

  a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.busy && ctrl.uw.jmp != dsi_pkg::JMP_END |-> rem_r != '0)
    else $error("sub-step running with no time left");

  a_snap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.busy && ctrl.uw.jmp == dsi_pkg::JMP_END && out_free
    |=> out_valid_r && (!rest_r || (pos_r == '0 && vel_r == '0)))
    else $error("resting update result not snapped to zero");

endmodule
`default_nettype wire
